// ===== rtl/core/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sparse triplet store
// Sizes of the cell row, entry layout, command codes and cell control.
// ----------------------------------------------------------------------------
package sst_pkg;

   localparam int CAPACITY   = 64;
   localparam int COORD_BITS = 8;
   localparam int DATA_W     = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int COUNT_W    = $clog2(CAPACITY + 1);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DATA_W-1:0]     data_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [COUNT_W-1:0]    count_type;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_SET   = 2'd1,
      CMD_GET   = 2'd2,
      CMD_ACC   = 2'd3
   } cmd_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
      data_type  value;
   } entry_type;

   typedef struct packed {
      logic      match_en;
      logic      shift_en;
      logic      load_en;
      logic      set_en;
      idx_type   pos;
      count_type count;
      entry_type req;
   } cell_ctl_type;

endpackage

// ===== rtl/core/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell: one storage cell of the triplet row
// Holds one entry, flags a key match, and takes its upper neighbor's entry
// when an entry at or below it is removed.
// ----------------------------------------------------------------------------
module sst_cell (
   input  logic                 clock,
   input  sst_pkg::idx_type      cell_idx,
   input  sst_pkg::cell_ctl_type ctl,
   input  sst_pkg::entry_type    next_entry,
   output sst_pkg::entry_type    entry,
   output logic                 hit
);

   sst_pkg::entry_type entry_ff;
   sst_pkg::entry_type entry_in;
   logic               hit_ff;
   logic               hit_in;
   logic               occupied;
   logic               at_pos;

   assign occupied = sst_pkg::count_type'(cell_idx) < ctl.count;
   assign at_pos   = cell_idx == ctl.pos;

   assign hit_in = ctl.match_en && occupied
                   && entry_ff.row == ctl.req.row && entry_ff.col == ctl.req.col;

   always_comb begin
      entry_in = entry_ff;
      // close the gap: every cell at or above the removed one moves down
      if (ctl.shift_en && cell_idx >= ctl.pos) begin
         entry_in = next_entry;
      end else if (ctl.load_en && at_pos) begin
         entry_in = ctl.req;
      end else if (ctl.set_en && at_pos) begin
         entry_in.value = ctl.req.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== rtl/core/sst_select.sv =====
// ----------------------------------------------------------------------------
// sst_select: gather the matching cell
// Reduces the row of hit flags to a found flag, the cell position and the
// stored value of the matching cell. At most one cell matches.
// ----------------------------------------------------------------------------
module sst_select (
   input  logic               hits [sst_pkg::CAPACITY],
   input  sst_pkg::entry_type entries [sst_pkg::CAPACITY],
   output logic               found,
   output sst_pkg::idx_type   hit_idx,
   output sst_pkg::data_type  hit_value
);

   always_comb begin
      found     = 1'b0;
      hit_idx   = '0;
      hit_value = '0;
      for (int i = 0; i < sst_pkg::CAPACITY; i++) begin
         if (hits[i]) begin
            found     = 1'b1;
            hit_idx   = hit_idx | sst_pkg::idx_type'(i);
            hit_value = hit_value | entries[i].value;
         end
      end
   end

endmodule

// ===== rtl/core/sparse_triplet_store.sv =====
// A command is accepted while idle and then passes through the match, gather and
// update states (cell compare, hit gather, write-back into the cell row); the result
// strobe is registered from the update state. Busy is high in those states and no new
// command is taken until the block is idle again. The receiver cannot stall.
// Reset clears the entry count and the control state; cell contents stay
// unknown and are never read until written.
// ----------------------------------------------------------------------------
// sparse_triplet_store: sparse matrix as a compacted list of triplets
// Row of cells with parallel key compare; clear, set, get and accumulate.
// ----------------------------------------------------------------------------
module sparse_triplet_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_row_key,
   input  logic [7:0]         req_col_key,
   input  logic signed [31:0] req_data_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]         rsp_entry_count,
   output logic               rsp_store_full
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_MATCH = 4'b0010,
      S_READ  = 4'b0100,
      S_WRITE = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   sst_pkg::cmd_type      cmd_ff;
   sst_pkg::entry_type    req_ff;
   sst_pkg::count_type    count_ff, count_in;
   logic                  found_ff;
   sst_pkg::idx_type      idx_ff;
   sst_pkg::data_type     old_ff;
   logic                  rsp_valid_ff;
   sst_pkg::data_type     rsp_value_ff, rsp_value_in;
   logic                  rsp_full_ff, rsp_full_in;

   sst_pkg::cell_ctl_type ctl;
   sst_pkg::entry_type    entries [sst_pkg::CAPACITY];
   logic                  hits [sst_pkg::CAPACITY];
   logic                  sel_found;
   sst_pkg::idx_type      sel_idx;
   sst_pkg::data_type     sel_value;
   sst_pkg::data_type     new_value;
   logic                  accept;

   assign accept = start && state_ff == S_IDLE;
   assign busy   = state_ff != S_IDLE;

   // cell row: each cell sees its upper neighbor, the top one sees itself
   for (genvar g = 0; g < sst_pkg::CAPACITY; g++) begin : g_cell
      sst_cell u_cell (
         .clock      (clock),
         .cell_idx   (sst_pkg::idx_type'(g)),
         .ctl        (ctl),
         .next_entry (entries[(g + 1 < sst_pkg::CAPACITY) ? g + 1 : g]),
         .entry      (entries[g]),
         .hit        (hits[g])
      );
   end

   sst_select u_select (
      .hits      (hits),
      .entries   (entries),
      .found     (sel_found),
      .hit_idx   (sel_idx),
      .hit_value (sel_value)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_MATCH;
         S_MATCH: state_in = S_READ;
         S_READ:  state_in = S_WRITE;
         S_WRITE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign new_value = (cmd_ff == sst_pkg::CMD_ACC) ? old_ff + req_ff.value : req_ff.value;

   always_comb begin
      ctl          = '0;
      ctl.count    = count_ff;
      ctl.req      = req_ff;
      ctl.match_en = state_ff == S_MATCH;
      count_in     = count_ff;
      rsp_value_in = '0;
      rsp_full_in  = 1'b0;
      if (state_ff == S_WRITE) begin
         ctl.req.value = new_value;
         unique case (cmd_ff) inside
            sst_pkg::CMD_CLEAR: begin
               count_in = '0;
            end
            sst_pkg::CMD_GET: begin
               rsp_value_in = found_ff ? old_ff : '0;
            end
            sst_pkg::CMD_SET, sst_pkg::CMD_ACC: begin
               if (found_ff) begin
                  ctl.pos = idx_ff;
                  if (new_value == '0) begin
                     ctl.shift_en = 1'b1;
                     count_in     = count_ff - sst_pkg::count_type'(1);
                  end else begin
                     ctl.set_en   = 1'b1;
                     rsp_value_in = new_value;
                  end
               end else if (new_value != '0) begin
                  if (count_ff >= sst_pkg::count_type'(sst_pkg::CAPACITY)) begin
                     rsp_full_in = 1'b1;
                  end else begin
                     ctl.load_en  = 1'b1;
                     ctl.pos      = count_ff[sst_pkg::IDX_W-1:0];
                     count_in     = count_ff + sst_pkg::count_type'(1);
                     rsp_value_in = new_value;
                  end
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= state_ff == S_WRITE;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= sst_pkg::cmd_type'(req_cmd);
         req_ff.row   <= sst_pkg::coord_type'(req_row_key);
         req_ff.col   <= sst_pkg::coord_type'(req_col_key);
         req_ff.value <= sst_pkg::data_type'(req_data_value);
      end
      if (state_ff == S_READ) begin
         found_ff <= sel_found;
         idx_ff   <= sel_idx;
         old_ff   <= sel_value;
      end
      if (state_ff == S_WRITE) begin
         rsp_value_ff <= rsp_value_in;
         rsp_full_ff  <= rsp_full_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = signed'(rsp_value_ff);
   assign rsp_entry_count = 7'(count_ff);
   assign rsp_store_full  = rsp_full_ff;

endmodule
